/* hw/rtl/afs_pkg.sv */
// Shared codes, widths and defaults for the animation frame sequencer.
package afs_pkg;

    // Request codes carried by req_type
    localparam int REQ_W = 3;
    localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PLAY  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_STOP  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_JUMP  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_WRITE = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_SPEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd2;

    // Speed format: signed Q4.8
    localparam int SPEED_W   = 13;
    localparam int FRAC_BITS = 8;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 13'd256;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_FRAMES = 64;
    localparam int DEF_TIME_BITS  = 24;

endpackage

/* hw/rtl/afs_mod.sv */
// Restoring remainder unit: one dividend bit per cycle.
module afs_mod #(
    parameter int DVD_W = 37,
    parameter int DVS_W = 39
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVS_W-1:0] remainder
);

    localparam int CW = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             fits;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[DVD_W-1]};
        diff    = shifted - {1'b0, divisor};
        fits    = (shifted >= {1'b0, divisor});
    end

    // Sequence the iterations
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DVD_W);
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* hw/rtl/animation_frame_sequencer.sv */
// Top level of the animation frame sequencer: duration table, playback state and control.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------------
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in        | in_valid/in_ready    | req_type, delta_time, restart, target_frame,
//           |           |                      | jump_time, use_frame_time, frame_duration
//   out     | out       | out_valid/out_ready  | frame_index, frame_updated, playing
//
// Steps per item: stop, write, unknown and idle tick finish in the idle state; play and jump
// from the table read it in S_LOAD; a tick scales (S_MUL) and subtracts (S_SUB), then per frame
// boundary crossed reads the table once (S_STEP, S_ADD), or stops at the end. A looping overrun
// sweeps the table (S_SUM), then runs the remainder unit when it exceeds one whole pass. Reset
// clears control and configuration registers, not payload registers or the table, which is
// undefined until written. A result not yet taken holds in_ready low; cfg_ready stays high.
module animation_frame_sequencer #(
    parameter int MAX_FRAMES = afs_pkg::DEF_MAX_FRAMES,
    parameter int TIME_BITS  = afs_pkg::DEF_TIME_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [afs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [afs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [afs_pkg::REQ_W-1:0]      req_type,
    input  logic [TIME_BITS-1:0]           delta_time,
    input  logic                          restart,
    input  logic [$clog2(MAX_FRAMES)-1:0]  target_frame,
    input  logic [TIME_BITS-1:0]           jump_time,
    input  logic                          use_frame_time,
    input  logic [TIME_BITS-1:0]           frame_duration,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [$clog2(MAX_FRAMES)-1:0]  frame_index,
    output logic                          frame_updated,
    output logic                          playing
);

    import afs_pkg::*;

    localparam int FW     = $clog2(MAX_FRAMES);
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int PROD_W = TIME_BITS + SPEED_W;
    localparam int TL_W   = PROD_W + 1;
    localparam int TOT_W  = TIME_BITS + FRAC_BITS + CNT_W;
    localparam int DVD_W  = TL_W - 1;
    localparam int CMP_W  = (TOT_W > TL_W) ? TOT_W : TL_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAMES);

    // Sequencer states
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE = 4'd0;
    localparam logic [ST_W-1:0] S_LOAD = 4'd1;
    localparam logic [ST_W-1:0] S_MUL  = 4'd2;
    localparam logic [ST_W-1:0] S_SUB  = 4'd3;
    localparam logic [ST_W-1:0] S_SUM  = 4'd4;
    localparam logic [ST_W-1:0] S_WRAP = 4'd5;
    localparam logic [ST_W-1:0] S_MOD  = 4'd6;
    localparam logic [ST_W-1:0] S_STEP = 4'd7;
    localparam logic [ST_W-1:0] S_ADD  = 4'd8;

    // Configuration registers
    logic [SPEED_W-1:0] speed_reg;
    logic               loop_reg;
    logic [CNT_W-1:0]   fcount_reg;

    // Control state
    logic [ST_W-1:0]  state_reg, state_next;
    logic [FW-1:0]    cur_frame_reg, cur_frame_next;
    logic [TL_W-1:0]  tl_reg, tl_next;
    logic             active_reg, active_next;
    logic             sweep_vld_reg, sweep_vld_next;
    logic             out_valid_reg, out_valid_next;

    // Payload state
    logic [TIME_BITS-1:0] delta_reg, delta_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [TOT_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     sweep_idx_reg, sweep_idx_next;
    logic [FW-1:0]        out_frame_reg, out_frame_next;
    logic                 out_upd_reg, out_upd_next;
    logic                 out_play_reg, out_play_next;

    // Duration table
    logic [TIME_BITS-1:0] dur_mem [MAX_FRAMES];
    logic [TIME_BITS-1:0] rd_data_reg;
    logic                 rd_en;
    logic [FW-1:0]        rd_addr;
    logic                 wr_en;
    logic [TIME_BITS-1:0] wr_data;

    // Derived values
    logic                 in_fire;
    logic [CNT_W-1:0]     n_eff;
    logic [FW-1:0]        last_frame;
    logic [FW-1:0]        cur_clamped;
    logic [FW-1:0]        tgt_clamped;
    logic [FW-1:0]        play_frame;
    logic [SPEED_W-1:0]   speed_mag;
    logic [TL_W-1:0]      tl_sub;
    logic [TL_W-1:0]      tl_add;
    logic [TL_W-1:0]      m_mag;
    logic                 m_gt_sum;
    logic [FW-1:0]        step_frame;
    logic                 step_wrap;
    logic                 res_fire;
    logic                 res_upd;

    // Remainder unit
    logic                 mod_start;
    logic [DVD_W-1:0]     mod_dvd;
    logic                 mod_done;
    logic [TOT_W-1:0]     mod_rem;

    afs_mod #(
        .DVD_W (DVD_W),
        .DVS_W (TOT_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dvd),
        .divisor   (sum_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Take configuration writes at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg  <= SPEED_RESET;
            loop_reg   <= 1'b0;
            fcount_reg <= CNT_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PLAY_SPEED:  speed_reg  <= cfg_data[SPEED_W-1:0];
                CFG_LOOP_ENABLE: loop_reg   <= cfg_data[0];
                CFG_FRAME_COUNT: fcount_reg <= cfg_data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Clamp the frame count and frames into the sequence
    always_comb
    begin
        if (fcount_reg == '0)
            n_eff = CNT_W'(1);
        else if (fcount_reg > MAX_CNT)
            n_eff = MAX_CNT;
        else
            n_eff = fcount_reg;
        last_frame  = FW'(n_eff - CNT_W'(1));
        cur_clamped = (cur_frame_reg > last_frame) ? last_frame : cur_frame_reg;
        tgt_clamped = (target_frame > last_frame) ? last_frame : target_frame;
        play_frame  = restart ? '0 : cur_clamped;
    end

    // Arithmetic on the remaining time
    always_comb
    begin
        speed_mag = speed_reg[SPEED_W-1] ? (SPEED_W'(0) - speed_reg) : speed_reg;
        tl_sub    = tl_reg - TL_W'(prod_reg);
        tl_add    = tl_reg + TL_W'({rd_data_reg, {FRAC_BITS{1'b0}}});
        m_mag     = TL_W'(0) - tl_reg;
        m_gt_sum  = CMP_W'(m_mag) > CMP_W'(sum_reg);
        mod_dvd   = DVD_W'(m_mag - TL_W'(1));
    end

    // Next frame in the playing direction
    always_comb
    begin
        step_wrap  = 1'b0;
        step_frame = cur_frame_reg;
        if (!speed_reg[SPEED_W-1])
        begin
            if (cur_frame_reg >= last_frame)
            begin
                step_wrap  = 1'b1;
                step_frame = '0;
            end
            else
            begin
                step_frame = cur_frame_reg + FW'(1);
            end
        end
        else
        begin
            if (cur_frame_reg == '0)
            begin
                step_wrap  = 1'b1;
                step_frame = last_frame;
            end
            else
            begin
                step_frame = cur_frame_reg - FW'(1);
            end
        end
    end

    // Accept only when idle and the result slot is free or draining
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;
    assign wr_data  = (frame_duration == '0) ? TIME_BITS'(1) : frame_duration;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_frame_next = cur_frame_reg;
        tl_next        = tl_reg;
        active_next    = active_reg;
        sweep_vld_next = 1'b0;
        delta_next     = delta_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        sweep_idx_next = sweep_idx_reg;
        rd_en          = 1'b0;
        rd_addr        = cur_frame_reg;
        wr_en          = 1'b0;
        mod_start      = 1'b0;
        res_fire       = 1'b0;
        res_upd        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (req_type)
                        REQ_TICK:
                        begin
                            if (!active_reg)
                            begin
                                res_fire = 1'b1;
                            end
                            else
                            begin
                                cur_frame_next = cur_clamped;
                                delta_next     = delta_time;
                                state_next     = S_MUL;
                            end
                        end
                        REQ_PLAY:
                        begin
                            cur_frame_next = play_frame;
                            rd_en          = 1'b1;
                            rd_addr        = play_frame;
                            active_next    = 1'b1;
                            state_next     = S_LOAD;
                        end
                        REQ_STOP:
                        begin
                            active_next = 1'b0;
                            res_fire    = 1'b1;
                        end
                        REQ_JUMP:
                        begin
                            cur_frame_next = tgt_clamped;
                            if (use_frame_time)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = tgt_clamped;
                                state_next = S_LOAD;
                            end
                            else
                            begin
                                tl_next  = TL_W'({jump_time, {FRAC_BITS{1'b0}}});
                                res_fire = 1'b1;
                                res_upd  = 1'b1;
                            end
                        end
                        REQ_WRITE:
                        begin
                            wr_en    = (CNT_W'(target_frame) < MAX_CNT);
                            res_fire = 1'b1;
                        end
                        default:
                        begin
                            res_fire = 1'b1;
                        end
                    endcase
                end
            end
            // Load the frame's own duration
            S_LOAD:
            begin
                tl_next    = TL_W'({rd_data_reg, {FRAC_BITS{1'b0}}});
                res_fire   = 1'b1;
                res_upd    = 1'b1;
                state_next = S_IDLE;
            end
            // Scale the elapsed time by the speed magnitude
            S_MUL:
            begin
                prod_next  = PROD_W'(speed_mag) * PROD_W'(delta_reg);
                state_next = S_SUB;
            end
            // Take the scaled time off and decide how to go on
            S_SUB:
            begin
                tl_next = tl_sub;
                priority if (!tl_sub[TL_W-1] && (tl_sub != '0))
                begin
                    res_fire   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (tl_sub == '0)
                begin
                    res_fire   = 1'b1;
                    res_upd    = 1'b1;
                    state_next = S_IDLE;
                end
                else if (loop_reg)
                begin
                    sum_next       = '0;
                    sweep_idx_next = '0;
                    state_next     = S_SUM;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            // Sweep the table to total one whole pass
            S_SUM:
            begin
                if (sweep_vld_reg)
                    sum_next = sum_reg + TOT_W'({rd_data_reg, {FRAC_BITS{1'b0}}});
                if (sweep_idx_reg < n_eff)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = sweep_idx_reg[FW-1:0];
                    sweep_idx_next = sweep_idx_reg + CNT_W'(1);
                    sweep_vld_next = 1'b1;
                end
                else if (!sweep_vld_reg)
                begin
                    state_next = S_WRAP;
                end
            end
            // Drop whole passes when the overrun exceeds one; a zero pass total ends at zero time
            S_WRAP:
            begin
                priority if (sum_reg == '0)
                begin
                    tl_next    = '0;
                    res_fire   = 1'b1;
                    res_upd    = 1'b1;
                    state_next = S_IDLE;
                end
                else if (m_gt_sum)
                begin
                    mod_start  = 1'b1;
                    state_next = S_MOD;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            // Wait for the remainder of the overrun
            S_MOD:
            begin
                if (mod_done)
                begin
                    tl_next    = TL_W'(0) - (TL_W'(mod_rem) + TL_W'(1));
                    state_next = S_STEP;
                end
            end
            // Advance one frame, or stop at the sequence end
            S_STEP:
            begin
                if (step_wrap && !loop_reg)
                begin
                    active_next = 1'b0;
                    res_fire    = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cur_frame_next = step_frame;
                    rd_en          = 1'b1;
                    rd_addr        = step_frame;
                    state_next     = S_ADD;
                end
            end
            // Add the entered frame's duration
            S_ADD:
            begin
                tl_next = tl_add;
                if (tl_add[TL_W-1])
                begin
                    state_next = S_STEP;
                end
                else
                begin
                    res_fire   = 1'b1;
                    res_upd    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register: hold until taken, load on a finished item
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_frame_next = out_frame_reg;
        out_upd_next   = out_upd_reg;
        out_play_next  = out_play_reg;
        if (res_fire)
        begin
            out_valid_next = 1'b1;
            out_frame_next = cur_frame_next;
            out_upd_next   = res_upd;
            out_play_next  = active_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_frame_reg <= '0;
            tl_reg        <= '0;
            active_reg    <= 1'b0;
            sweep_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_frame_reg <= cur_frame_next;
            tl_reg        <= tl_next;
            active_reg    <= active_next;
            sweep_vld_reg <= sweep_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        delta_reg     <= delta_next;
        prod_reg      <= prod_next;
        sum_reg       <= sum_next;
        sweep_idx_reg <= sweep_idx_next;
        out_frame_reg <= out_frame_next;
        out_upd_reg   <= out_upd_next;
        out_play_reg  <= out_play_next;
    end

    // Duration table with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            dur_mem[target_frame] <= wr_data;
        if (rd_en)
            rd_data_reg <= dur_mem[rd_addr];
    end

    assign out_valid     = out_valid_reg;
    assign frame_index   = out_frame_reg;
    assign frame_updated = out_upd_reg;
    assign playing       = out_play_reg;

    // No result waits while an item is still in progress
    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result pending while an item is in progress");

    // Active playback never rests with a negative remaining time
    a_idle_time_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && active_reg) |-> !tl_reg[TL_W-1])
        else $error("negative remaining time while playing and idle");

    // Frame stepping only happens with time still owed
    a_step_negative: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> tl_reg[TL_W-1])
        else $error("frame step with non-negative remaining time");

    // The remainder unit finishes only while it is awaited
    a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == S_MOD))
        else $error("remainder finished outside its wait state");

    // The remainder is below one whole pass
    a_mod_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (mod_rem < sum_reg))
        else $error("remainder not below the pass total");

endmodule

/* tb/sv/animation_frame_sequencer_tb.sv */
// Self-checking testbench for the animation frame sequencer: random and directed items, scoreboard.
`timescale 1ns / 1ps

module animation_frame_sequencer_tb;

    import afs_pkg::*;

    localparam int TB_FRAMES  = DEF_MAX_FRAMES;
    localparam int TB_TIME_W  = DEF_TIME_BITS;
    localparam int TB_INDEX_W = $clog2(DEF_MAX_FRAMES);
    localparam int RUN_LIMIT  = 1000000;
    localparam int HOLD_SPAN  = 400;
    localparam int HOLD_FIRST = 300;
    localparam int HOLD_STEP  = 500;

    // Codes the block must ignore
    localparam logic [REQ_W-1:0]     REQ_RESERVED = REQ_WRITE + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]      kind;
        logic [TB_TIME_W-1:0]  delta_time;
        logic                  restart;
        logic [TB_INDEX_W-1:0] target;
        logic [TB_TIME_W-1:0]  jump_time;
        logic                  use_frame_time;
        logic [TB_TIME_W-1:0]  frame_duration;
    } seq_req_t;

    typedef struct packed {
        logic [TB_INDEX_W-1:0] frame;
        logic                  updated;
        logic                  playing;
    } frame_status_t;

    // DUT connections
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [REQ_W-1:0] req_type = '0;
    logic [TB_TIME_W-1:0] delta_time = '0;
    logic restart = 1'b0;
    logic [TB_INDEX_W-1:0] target_frame = '0;
    logic [TB_TIME_W-1:0] jump_time = '0;
    logic use_frame_time = 1'b0;
    logic [TB_TIME_W-1:0] frame_duration = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [TB_INDEX_W-1:0] frame_index;
    logic frame_updated;
    logic playing;

    // Items waiting to be offered, and results still owed by the block
    seq_req_t      pending_reqs[$];
    seq_req_t      bus_req;
    frame_status_t owed_status[$];

    // Sequencer state as the testbench tracks it
    int              speed_q = 256;
    bit              loop_q = 1'b0;
    int              count_q = 1;
    bit [TB_TIME_W-1:0] dur_tbl [TB_FRAMES];
    int              cur_frame = 0;
    longint          time_left_q = 0;
    bit              active_q = 1'b0;

    // Bookkeeping
    int cycle_count = 0;
    int accepted_items = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int settings_used = 0;
    int kind_seen [8];
    int steps_taken = 0;
    int wraps_taken = 0;
    int end_stops = 0;
    int passes_folded = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int holds_done = 0;
    int pattern_age = 0;
    logic [15:0] stall_bits = 16'hFFFF;

    animation_frame_sequencer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .delta_time     (delta_time),
        .restart        (restart),
        .target_frame   (target_frame),
        .jump_time      (jump_time),
        .use_frame_time (use_frame_time),
        .frame_duration (frame_duration),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_index    (frame_index),
        .frame_updated  (frame_updated),
        .playing        (playing)
    );

    always
    begin
        #6;
        clk = 1'b1;
        #6;
        clk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    function automatic int frames_in_use();
        if (count_q == 0)
            return 1;
        if (count_q > TB_FRAMES)
            return TB_FRAMES;
        return count_q;
    endfunction

    function automatic longint scaled_duration(input int idx);
        return longint'(dur_tbl[idx]) << FRAC_BITS;
    endfunction

    function automatic void store_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_PLAY_SPEED:  speed_q = int'($signed(data));
            CFG_LOOP_ENABLE: loop_q = data[0];
            CFG_FRAME_COUNT: count_q = int'(data[6:0]);
            default: ;
        endcase
    endfunction

    // Burn playback time and step through frames; return whether the frame was applied
    function automatic bit run_tick(input logic [TB_TIME_W-1:0] dt);
        int     n;
        bit     fwd;
        longint mag;
        longint total;
        longint k;
        n = frames_in_use();
        fwd = (speed_q >= 0);
        mag = fwd ? speed_q : -speed_q;
        if (!active_q)
            return 1'b0;
        if (cur_frame > n - 1)
            cur_frame = n - 1;
        time_left_q -= mag * longint'(dt);
        if (time_left_q > 0)
            return 1'b0;
        // skip whole passes of a looping sequence at once
        if (time_left_q < 0 && loop_q)
        begin
            total = 0;
            for (int i = 0; i < n; i++)
                total += scaled_duration(i);
            if (total == 0)
            begin
                time_left_q = 0;
                return 1'b1;
            end
            if (-time_left_q > total)
            begin
                k = (-time_left_q - 1) / total;
                time_left_q += k * total;
                passes_folded++;
            end
        end
        while (time_left_q < 0)
        begin
            if (fwd ? (cur_frame >= n - 1) : (cur_frame == 0))
            begin
                if (!loop_q)
                begin
                    active_q = 1'b0;
                    end_stops++;
                    return 1'b0;
                end
                cur_frame = fwd ? 0 : n - 1;
                wraps_taken++;
            end
            else
            begin
                cur_frame = fwd ? cur_frame + 1 : cur_frame - 1;
            end
            steps_taken++;
            time_left_q += scaled_duration(cur_frame);
        end
        return 1'b1;
    endfunction

    function automatic frame_status_t apply_request(input seq_req_t r);
        frame_status_t res;
        int            n;
        n = frames_in_use();
        res.updated = 1'b0;
        kind_seen[r.kind]++;
        case (r.kind)
            REQ_TICK:
                res.updated = run_tick(r.delta_time);
            REQ_PLAY:
            begin
                if (r.restart)
                    cur_frame = 0;
                else if (cur_frame > n - 1)
                    cur_frame = n - 1;
                time_left_q = scaled_duration(cur_frame);
                active_q = 1'b1;
                res.updated = 1'b1;
            end
            REQ_STOP:
                active_q = 1'b0;
            REQ_JUMP:
            begin
                cur_frame = (int'(r.target) > n - 1) ? n - 1 : int'(r.target);
                if (r.use_frame_time)
                    time_left_q = scaled_duration(cur_frame);
                else
                    time_left_q = longint'(r.jump_time) << FRAC_BITS;
                res.updated = 1'b1;
            end
            REQ_WRITE:
                dur_tbl[r.target] = (r.frame_duration == '0) ? TB_TIME_W'(1)
                                                             : r.frame_duration;
            default: ;
        endcase
        res.frame = cur_frame[TB_INDEX_W-1:0];
        res.playing = active_q;
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // Append an item to the list still to be offered
    function automatic void add_pending(input seq_req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic logic [TB_TIME_W-1:0] pick_delta();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2, 3:    return TB_TIME_W'($urandom);
            4, 5, 6: return TB_TIME_W'($urandom_range(0, 2047));
            default: return TB_TIME_W'($urandom_range(0, 80));
        endcase
    endfunction

    function automatic logic [TB_TIME_W-1:0] pick_duration();
        case ($urandom_range(0, 39))
            0:       return '0;
            1:       return '1;
            2:       return TB_TIME_W'($urandom);
            3, 4:    return TB_TIME_W'($urandom_range(1, 4095));
            default: return TB_TIME_W'($urandom_range(1, 40));
        endcase
    endfunction

    // Random contents in every field; the kind decides which ones matter
    function automatic seq_req_t make_req(input logic [REQ_W-1:0] kind);
        seq_req_t r;
        r.kind = kind;
        r.delta_time = pick_delta();
        r.restart = 1'($urandom_range(0, 1));
        r.target = TB_INDEX_W'($urandom_range(0, TB_FRAMES - 1));
        r.jump_time = ($urandom_range(0, 3) == 0) ? TB_TIME_W'($urandom)
                                                  : TB_TIME_W'($urandom_range(0, 200));
        r.use_frame_time = 1'($urandom_range(0, 1));
        r.frame_duration = pick_duration();
        return r;
    endfunction

    // Set the fields that matter for a directed item
    function automatic seq_req_t shaped(input logic [REQ_W-1:0] kind,
                                        input logic [TB_TIME_W-1:0] value,
                                        input logic [TB_INDEX_W-1:0] tgt, input bit flag);
        seq_req_t r;
        r = make_req(kind);
        r.delta_time = value;
        r.jump_time = value;
        r.frame_duration = value;
        r.target = tgt;
        r.restart = flag;
        r.use_frame_time = flag;
        return r;
    endfunction

    // Mostly play followed by a run of mostly ticks, some lone noise items
    task automatic queue_playback(input int budget);
        seq_req_t r;
        int       left;
        int       run;
        int       sel;
        left = budget;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_pending(make_req(REQ_W'($urandom)));
                left--;
            end
            else
            begin
                add_pending(make_req(REQ_PLAY));
                left--;
                run = $urandom_range(3, 12);
                for (int k = 0; k < run && left > 0; k++)
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 78)
                        r = make_req(REQ_TICK);
                    else if (sel < 84)
                        r = make_req(REQ_JUMP);
                    else if (sel < 89)
                        r = make_req(REQ_WRITE);
                    else if (sel < 92)
                        r = make_req(REQ_STOP);
                    else if (sel < 97)
                        r = make_req(REQ_PLAY);
                    else
                        r = make_req(REQ_RESERVED + REQ_W'($urandom_range(0, 2)));
                    add_pending(r);
                    left--;
                end
            end
        end
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        store_cfg(idx, data);
    endtask

    // Junk in the unused upper bits must be ignored
    task automatic apply_settings(input int speed, input bit loop_on, input int frames);
        write_cfg(CFG_PLAY_SPEED, CFG_DATA_W'(speed));
        write_cfg(CFG_LOOP_ENABLE, {12'($urandom), loop_on});
        write_cfg(CFG_FRAME_COUNT, {6'($urandom), 7'(frames)});
        settings_used++;
    endtask

    // Wait until every item is taken and every result has come back
    task automatic drain_all();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || owed_status.size() != 0);
    endtask

    function automatic void flag_mismatch(input string what, input frame_status_t want,
                                          input frame_status_t got);
        if (mismatch_count < 10)
            $display("%0t: %s: expected frame %0d updated %0b playing %0b, got %0d %0b %0b",
                     $time, what, want.frame, want.updated, want.playing,
                     got.frame, got.updated, got.playing);
        mismatch_count++;
    endfunction

    // ---------------------------------------------------------------- input driver

    // Offer queued items in bursts; hold valid and payload until taken
    always @(posedge clk)
    begin : in_driver
        seq_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                owed_status.insert(owed_status.size(), apply_request(bus_req));
                accepted_items++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    nxt = pending_reqs.pop_front();
                    bus_req = nxt;
                    req_type <= nxt.kind;
                    delta_time <= nxt.delta_time;
                    restart <= nxt.restart;
                    target_frame <= nxt.target;
                    jump_time <= nxt.jump_time;
                    use_frame_time <= nxt.use_frame_time;
                    frame_duration <= nxt.frame_duration;
                    in_valid <= 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- output side

    // Hold off the output for a long stretch, twice during the run
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (holds_done < 2 && accepted_items >= HOLD_FIRST + holds_done * HOLD_STEP)
        begin
            hold_left <= HOLD_SPAN;
            holds_done <= holds_done + 1;
        end
    end

    // Stall on a rotating pattern, re-picked now and then
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (pattern_age == 0)
            begin
                pattern_age = 64;
                stall_bits = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0001;
            end
            pattern_age--;
            stall_bits = {stall_bits[0], stall_bits[15:1]};
            out_ready <= stall_bits[0] && hold_left == 0;
        end
    end

    // Check each result against the oldest one owed
    always @(posedge clk)
    begin : out_checker
        frame_status_t want;
        frame_status_t got;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            got.frame = frame_index;
            got.updated = frame_updated;
            got.playing = playing;
            if (owed_status.size() == 0)
            begin
                flag_mismatch("result with none owed", '0, got);
            end
            else
            begin
                want = owed_status.pop_front();
                if (got.frame !== want.frame || got.updated !== want.updated ||
                    got.playing !== want.playing)
                    flag_mismatch("wrong result", want, got);
            end
        end
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d results owed.", owed_status.size());
            $display("animation_frame_sequencer_tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- test sequence

    initial
    begin : stimulus
        int       phase_speed [8];
        bit       phase_loop [8];
        int       phase_count [8];
        phase_speed = '{256, 4095, -4096, -256, 0, 37, 128, -77};
        phase_loop = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        phase_count = '{64, 8, 5, 16, 4, 1, 0, 127};
        for (int i = 0; i < 8; i++)
            kind_seen[i] = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Fill the whole table before anything reads it
        for (int i = 0; i < TB_FRAMES; i++)
            add_pending(shaped(REQ_WRITE, TB_TIME_W'($urandom_range(1, 40)),
                               TB_INDEX_W'(i), 1'b0));
        drain_all();
        write_cfg(CFG_SPARE, '1);

        // Directed: looping forward at unit speed over all frames
        apply_settings(256, 1'b1, TB_FRAMES);
        add_pending(shaped(REQ_WRITE, TB_TIME_W'(10), TB_INDEX_W'(0), 1'b0));
        add_pending(shaped(REQ_WRITE, TB_TIME_W'(20), TB_INDEX_W'(1), 1'b0));
        add_pending(shaped(REQ_WRITE, '0, TB_INDEX_W'(62), 1'b0));
        add_pending(shaped(REQ_WRITE, '1, TB_INDEX_W'(TB_FRAMES - 1), 1'b0));
        add_pending(shaped(REQ_PLAY, '0, '0, 1'b1));
        // land exactly on zero, then cross one boundary, then no time at all
        add_pending(shaped(REQ_TICK, TB_TIME_W'(10), '0, 1'b0));
        add_pending(shaped(REQ_TICK, TB_TIME_W'(1), '0, 1'b0));
        add_pending(shaped(REQ_TICK, '0, '0, 1'b0));
        add_pending(shaped(REQ_JUMP, '0, '1, 1'b1));
        add_pending(shaped(REQ_TICK, '1, '0, 1'b0));
        // wrap from the last frame
        add_pending(shaped(REQ_TICK, TB_TIME_W'(1), '0, 1'b0));
        add_pending(shaped(REQ_JUMP, '1, TB_INDEX_W'(5), 1'b0));
        add_pending(shaped(REQ_STOP, '0, '0, 1'b0));
        add_pending(shaped(REQ_TICK, TB_TIME_W'(100), '0, 1'b0));
        add_pending(shaped(REQ_PLAY, '0, '0, 1'b0));
        for (int i = 0; i < 3; i++)
            add_pending(make_req(REQ_RESERVED + REQ_W'(i)));
        // overrun by many whole passes
        add_pending(shaped(REQ_WRITE, TB_TIME_W'(7), TB_INDEX_W'(TB_FRAMES - 1), 1'b0));
        add_pending(shaped(REQ_TICK, '1, '0, 1'b0));
        drain_all();

        // Directed: fastest reverse, no looping, frame beyond the count
        apply_settings(-4096, 1'b0, 3);
        add_pending(shaped(REQ_PLAY, '0, '0, 1'b0));
        add_pending(shaped(REQ_TICK, '1, '0, 1'b0));
        add_pending(shaped(REQ_TICK, TB_TIME_W'(5), '0, 1'b0));
        add_pending(shaped(REQ_JUMP, '0, '1, 1'b0));
        add_pending(shaped(REQ_PLAY, '0, '0, 1'b1));
        add_pending(shaped(REQ_TICK, TB_TIME_W'(1), '0, 1'b0));
        drain_all();

        // Random playback under each register setting
        for (int p = 0; p < 8; p++)
        begin
            apply_settings(phase_speed[p], phase_loop[p], phase_count[p]);
            queue_playback(133);
            drain_all();
        end

        repeat (300) @(posedge clk);
        if (owed_status.size() != 0)
        begin
            $display("%0d results never arrived.", owed_status.size());
            mismatch_count += owed_status.size();
        end

        $display("Sent %0d items (%0d ticks, %0d plays, %0d jumps, %0d writes, %0d stops)",
                 accepted_items, kind_seen[REQ_TICK], kind_seen[REQ_PLAY],
                 kind_seen[REQ_JUMP], kind_seen[REQ_WRITE], kind_seen[REQ_STOP]);
        $display("under %0d settings; checked %0d results: %0d steps, %0d wraps, %0d end stops, %0d folds.",
                 settings_used, results_checked, steps_taken, wraps_taken, end_stops,
                 passes_folded);
        if (mismatch_count == 0)
            $display("animation_frame_sequencer_tb: PASS");
        else
            $display("animation_frame_sequencer_tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/afs_pkg.sv
hw/rtl/afs_mod.sv
hw/rtl/animation_frame_sequencer.sv
tb/sv/animation_frame_sequencer_tb.sv
